>>> rtl/core/pidp_pkg.sv
// ----------------------------------------------------------------------------
// pidp_pkg
// shared widths, register indexes, controller states and command/status types
// ----------------------------------------------------------------------------
package pidp_pkg;

	localparam int POS_W    = 16;
	localparam int ERR_W    = 17;
	localparam int GAIN_W   = 32;
	localparam int FRAC_W   = 17;
	localparam int LIM_W    = 16;
	localparam int FILT_W   = 36;
	localparam int INTEG_W  = 48;
	localparam int PTERM_W  = 51;
	localparam int U_W      = 54;
	localparam int USAT_W   = 34;
	localparam int MUL_A_W  = 36;
	localparam int MUL_B_W  = 32;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W  = 32;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] REG_KP       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Q_ENTER  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Q_EXIT   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 4'd7;

	localparam logic [GAIN_W-1:0] KP_RST       = 32'd65536;
	localparam logic [GAIN_W-1:0] KI_RST       = 32'd0;
	localparam logic [GAIN_W-1:0] KD_RST       = 32'd0;
	localparam logic [FRAC_W-1:0] ALPHA_RST    = 17'd65536;
	localparam logic [LIM_W-1:0]  LIMIT_RST    = 16'd1000;
	localparam logic [LIM_W-1:0]  Q_ENTER_RST  = 16'd0;
	localparam logic [LIM_W-1:0]  Q_EXIT_RST   = 16'd0;
	localparam logic [FRAC_W-1:0] DUTY_MAX_RST = 17'd6554;

	typedef enum logic [1:0] {
		OP_FILT,
		OP_PROP,
		OP_DERIV,
		OP_INTEG
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_F,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_SAT,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_start;
		op_t  start_op;
		logic cap;
		op_t  cap_op;
		logic sat;
		logic div_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/pidp_in_if.sv
// ----------------------------------------------------------------------------
// pidp_in_if
// input channel: reference and measured position with valid/ready
// ----------------------------------------------------------------------------
interface pidp_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [pidp_pkg::POS_W-1:0] reference_position;
	logic signed [pidp_pkg::POS_W-1:0] measured_position;

	modport source (output valid, output reference_position, output measured_position,
		input ready);
	modport sink (input valid, input reference_position, input measured_position,
		output ready);
endinterface

>>> rtl/core/pidp_out_if.sv
// ----------------------------------------------------------------------------
// pidp_out_if
// result channel: direction, duty, quiet flag and effort with valid/ready
// ----------------------------------------------------------------------------
interface pidp_out_if;
	logic                               valid;
	logic                               ready;
	logic                               phase_positive;
	logic [pidp_pkg::FRAC_W-1:0]        duty_fraction;
	logic                               quiet_active;
	logic signed [pidp_pkg::ERR_W-1:0]  effort;

	modport source (output valid, output phase_positive, output duty_fraction,
		output quiet_active, output effort, input ready);
	modport sink (input valid, input phase_positive, input duty_fraction,
		input quiet_active, input effort, output ready);
endinterface

>>> rtl/core/pidp_mul.sv
// ----------------------------------------------------------------------------
// pidp_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pidp_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pidp_pkg::MUL_A_W-1:0]     a,
	input  logic [pidp_pkg::MUL_B_W-1:0]     b,
	output logic                             done,
	output logic [pidp_pkg::MUL_P_W-1:0]     prod
);

	localparam int CNT_W = $clog2(pidp_pkg::MUL_B_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pidp_pkg::MUL_B_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [pidp_pkg::MUL_P_W-1:0]  acc_q;
	logic [pidp_pkg::MUL_P_W-1:0]  a_q;
	logic [pidp_pkg::MUL_B_W-1:0]  b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {{pidp_pkg::MUL_B_W{1'b0}}, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[pidp_pkg::MUL_P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[pidp_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> rtl/core/pidp_div.sv
// ----------------------------------------------------------------------------
// pidp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pidp_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pidp_pkg::DIV_N_W-1:0]   dividend,
	input  logic [pidp_pkg::LIM_W-1:0]     divisor,
	output logic                           done,
	output logic [pidp_pkg::DIV_N_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(pidp_pkg::DIV_N_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pidp_pkg::DIV_N_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [pidp_pkg::LIM_W-1:0]    rem_q;
	logic [pidp_pkg::LIM_W-1:0]    dsr_q;
	logic [pidp_pkg::DIV_N_W-1:0]  dvd_q;
	logic [pidp_pkg::LIM_W:0]      trial;
	logic                          ge;

	assign trial = {rem_q, dvd_q[pidp_pkg::DIV_N_W-1]};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? pidp_pkg::LIM_W'(trial - {1'b0, dsr_q}) : trial[pidp_pkg::LIM_W-1:0];
			dvd_q <= {dvd_q[pidp_pkg::DIV_N_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

>>> rtl/core/pidp_datapath.sv
// ----------------------------------------------------------------------------
// pidp_datapath
// configuration, controller state, operand selection, result capture, output
// ----------------------------------------------------------------------------
module pidp_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pidp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidp_pkg::CFG_DAT_W-1:0]        cfg_data,
	input  logic signed [pidp_pkg::POS_W-1:0]     reference_position,
	input  logic signed [pidp_pkg::POS_W-1:0]     measured_position,
	input  pidp_pkg::cmd_t                        cmd,
	output pidp_pkg::status_t                     stat,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  phase_positive,
	output logic [pidp_pkg::FRAC_W-1:0]           duty_fraction,
	output logic                                  quiet_active,
	output logic signed [pidp_pkg::ERR_W-1:0]     effort
);

	// configuration registers
	logic [pidp_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
	logic [pidp_pkg::FRAC_W-1:0] alpha_q, duty_max_q;
	logic [pidp_pkg::LIM_W-1:0]  limit_q, q_enter_q, q_exit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= pidp_pkg::KP_RST;
			ki_q       <= pidp_pkg::KI_RST;
			kd_q       <= pidp_pkg::KD_RST;
			alpha_q    <= pidp_pkg::ALPHA_RST;
			limit_q    <= pidp_pkg::LIMIT_RST;
			q_enter_q  <= pidp_pkg::Q_ENTER_RST;
			q_exit_q   <= pidp_pkg::Q_EXIT_RST;
			duty_max_q <= pidp_pkg::DUTY_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pidp_pkg::REG_KP:       kp_q       <= cfg_data;
				pidp_pkg::REG_KI:       ki_q       <= cfg_data;
				pidp_pkg::REG_KD:       kd_q       <= cfg_data;
				pidp_pkg::REG_ALPHA:    alpha_q    <= cfg_data[pidp_pkg::FRAC_W-1:0];
				pidp_pkg::REG_LIMIT:    limit_q    <= cfg_data[pidp_pkg::LIM_W-1:0];
				pidp_pkg::REG_Q_ENTER:  q_enter_q  <= cfg_data[pidp_pkg::LIM_W-1:0];
				pidp_pkg::REG_Q_EXIT:   q_exit_q   <= cfg_data[pidp_pkg::LIM_W-1:0];
				pidp_pkg::REG_DUTY_MAX: duty_max_q <= cfg_data[pidp_pkg::FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	logic [pidp_pkg::FRAC_W-1:0] alpha_eff, dmax_eff;
	logic [pidp_pkg::LIM_W-1:0]  limit_eff;

	assign alpha_eff = (alpha_q > pidp_pkg::ONE_Q16) ? pidp_pkg::ONE_Q16 : alpha_q;
	assign dmax_eff  = (duty_max_q > pidp_pkg::ONE_Q16) ? pidp_pkg::ONE_Q16 : duty_max_q;
	assign limit_eff = (limit_q == '0) ? pidp_pkg::LIM_W'(1) : limit_q;

	// per-item and loop state
	logic signed [pidp_pkg::ERR_W-1:0]   e_q, d_q;
	logic [pidp_pkg::ERR_W-1:0]          abs_e_q;
	logic signed [pidp_pkg::POS_W-1:0]   prev_pos_q;
	logic                                quiet_q, dir_q;
	logic signed [pidp_pkg::FILT_W-1:0]  f_q;
	logic signed [pidp_pkg::INTEG_W-1:0] integ_q, ni_q;
	logic signed [pidp_pkg::PTERM_W-1:0] p_q;
	logic signed [pidp_pkg::U_W-1:0]     u_q;
	logic signed [pidp_pkg::USAT_W-1:0]  usat_q;

	function automatic logic signed [pidp_pkg::ERR_W-1:0] ERR_W_sx(
		input logic signed [pidp_pkg::POS_W-1:0] v);
		ERR_W_sx = {v[pidp_pkg::POS_W-1], v};
	endfunction

	// load
	logic signed [pidp_pkg::ERR_W-1:0] e_new, d_new;
	logic [pidp_pkg::ERR_W-1:0]        abs_e_new;
	logic                              quiet_new;

	assign e_new = ERR_W_sx(reference_position) - ERR_W_sx(measured_position);
	assign d_new = ERR_W_sx(measured_position) - ERR_W_sx(prev_pos_q);
	assign abs_e_new = e_new[pidp_pkg::ERR_W-1] ? pidp_pkg::ERR_W'(-e_new) : e_new;
	assign quiet_new = quiet_q ? !(abs_e_new > {1'b0, q_exit_q})
	                           : (abs_e_new < {1'b0, q_enter_q});

	// filter difference and magnitudes
	logic signed [pidp_pkg::FILT_W:0] diff;
	logic                             diff_neg;
	logic [pidp_pkg::FILT_W:0]        diff_abs;
	logic [pidp_pkg::FILT_W-1:0]      f_abs;
	logic [pidp_pkg::GAIN_W-1:0]      f_mag;

	assign diff = {{4{d_q[pidp_pkg::ERR_W-1]}}, d_q, 16'b0} - {f_q[pidp_pkg::FILT_W-1], f_q};
	assign diff_neg = diff[pidp_pkg::FILT_W];
	assign diff_abs = diff_neg ? (pidp_pkg::FILT_W+1)'(-diff) : diff;
	assign f_abs = f_q[pidp_pkg::FILT_W-1] ? pidp_pkg::FILT_W'(-f_q) : f_q;
	assign f_mag = (f_abs[pidp_pkg::FILT_W-1:pidp_pkg::GAIN_W] != '0) ? '1
	             : f_abs[pidp_pkg::GAIN_W-1:0];

	// shared multiplier
	logic [pidp_pkg::MUL_A_W-1:0] mul_a;
	logic [pidp_pkg::MUL_B_W-1:0] mul_b;
	logic [pidp_pkg::MUL_P_W-1:0] mul_prod;
	logic                         mul_done;

	always_comb begin
		unique case (cmd.start_op)
			pidp_pkg::OP_FILT: begin
				mul_a = diff_abs[pidp_pkg::MUL_A_W-1:0];
				mul_b = {15'b0, alpha_eff};
			end
			pidp_pkg::OP_PROP: begin
				mul_a = {4'b0, kp_q};
				mul_b = {15'b0, abs_e_q};
			end
			pidp_pkg::OP_DERIV: begin
				mul_a = {4'b0, f_mag};
				mul_b = kd_q;
			end
			pidp_pkg::OP_INTEG: begin
				mul_a = {4'b0, ki_q};
				mul_b = {15'b0, abs_e_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pidp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// capture terms
	logic [pidp_pkg::MUL_P_W-1:0]         f_step_full;
	logic [pidp_pkg::FILT_W+1:0]          f_step;
	logic signed [pidp_pkg::FILT_W+1:0]   f_next;
	logic signed [pidp_pkg::PTERM_W-1:0]  ep_prod;
	logic [pidp_pkg::INTEG_W:0]           d_mag;
	logic signed [pidp_pkg::INTEG_W+1:0]  d_term;
	logic signed [pidp_pkg::U_W-1:0]      u_new;
	logic signed [pidp_pkg::PTERM_W:0]    ni_full;
	logic signed [pidp_pkg::INTEG_W-1:0]  ni_sat;

	// floor of the signed product over 2^16: negative values round away from zero
	assign f_step_full = diff_neg ? ((mul_prod + pidp_pkg::MUL_P_W'(16'hFFFF)) >> 16)
	                              : (mul_prod >> 16);
	assign f_step = f_step_full[pidp_pkg::FILT_W+1:0];
	assign f_next = {{2{f_q[pidp_pkg::FILT_W-1]}}, f_q}
	              + (diff_neg ? (pidp_pkg::FILT_W+2)'(-f_step) : f_step);

	assign ep_prod = e_q[pidp_pkg::ERR_W-1] ? pidp_pkg::PTERM_W'(-mul_prod[pidp_pkg::PTERM_W-1:0])
	                                        : mul_prod[pidp_pkg::PTERM_W-1:0];

	assign d_mag  = mul_prod[pidp_pkg::INTEG_W+16:16];
	assign d_term = f_q[pidp_pkg::FILT_W-1] ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
	assign u_new  = pidp_pkg::U_W'(p_q) + pidp_pkg::U_W'(integ_q) - pidp_pkg::U_W'(d_term);

	assign ni_full = (pidp_pkg::PTERM_W+1)'(integ_q) + (pidp_pkg::PTERM_W+1)'(ep_prod);
	always_comb begin
		if (ni_full[pidp_pkg::PTERM_W:pidp_pkg::INTEG_W-1] == '0
		    || ni_full[pidp_pkg::PTERM_W:pidp_pkg::INTEG_W-1] == '1) begin
			ni_sat = ni_full[pidp_pkg::INTEG_W-1:0];
		end else if (ni_full[pidp_pkg::PTERM_W]) begin
			ni_sat = {1'b1, {(pidp_pkg::INTEG_W-1){1'b0}}};
		end else begin
			ni_sat = {1'b0, {(pidp_pkg::INTEG_W-1){1'b1}}};
		end
	end

	// saturation against the limit
	logic signed [pidp_pkg::U_W-1:0]    lim_q16;
	logic                               over_hi, over_lo, integ_ok;
	logic signed [pidp_pkg::USAT_W-1:0] usat_new;
	logic [pidp_pkg::USAT_W-1:0]        usat_abs;

	assign lim_q16  = pidp_pkg::U_W'({limit_eff, 16'b0});
	assign over_hi  = (u_q > lim_q16);
	assign over_lo  = (u_q < -lim_q16);
	assign usat_new = over_hi ? lim_q16[pidp_pkg::USAT_W-1:0]
	                : over_lo ? pidp_pkg::USAT_W'(-lim_q16) : u_q[pidp_pkg::USAT_W-1:0];
	assign usat_abs = usat_new[pidp_pkg::USAT_W-1] ? pidp_pkg::USAT_W'(-usat_new) : usat_new;
	assign integ_ok = (!over_hi && !over_lo)
	               || (over_hi && e_q[pidp_pkg::ERR_W-1])
	               || (over_lo && !e_q[pidp_pkg::ERR_W-1] && (e_q != '0));

	// duty divider
	logic [pidp_pkg::DIV_N_W-1:0] quotient;
	logic                         div_done;

	pidp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (usat_abs[pidp_pkg::DIV_N_W-1:0]),
		.divisor  (limit_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
			quiet_q    <= 1'b0;
			dir_q      <= 1'b0;
			f_q        <= '0;
			integ_q    <= '0;
		end else begin
			if (cmd.load) begin
				prev_pos_q <= measured_position;
				quiet_q    <= quiet_new;
			end
			if (cmd.cap && cmd.cap_op == pidp_pkg::OP_FILT) begin
				f_q <= f_next[pidp_pkg::FILT_W-1:0];
			end
			if (cmd.sat) begin
				if (quiet_q) begin
					integ_q <= '0;
				end else begin
					dir_q <= usat_new[pidp_pkg::USAT_W-1];
					if (integ_ok) begin
						integ_q <= ni_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q     <= e_new;
			d_q     <= d_new;
			abs_e_q <= abs_e_new;
		end
		if (cmd.cap) begin
			unique case (cmd.cap_op)
				pidp_pkg::OP_PROP:  p_q  <= ep_prod;
				pidp_pkg::OP_DERIV: u_q  <= u_new;
				pidp_pkg::OP_INTEG: ni_q <= ni_sat;
				default: ;
			endcase
		end
		if (cmd.sat) begin
			usat_q <= usat_new;
		end
	end

	// output register
	logic [pidp_pkg::USAT_W-1:0]  out_abs;
	logic [pidp_pkg::ERR_W-1:0]   eff_mag;
	logic [pidp_pkg::FRAC_W-1:0]  duty_q17;
	logic                         out_valid_q;

	assign out_abs  = usat_q[pidp_pkg::USAT_W-1] ? pidp_pkg::USAT_W'(-usat_q) : usat_q;
	assign eff_mag  = out_abs[pidp_pkg::ERR_W+15:16];
	assign duty_q17 = (quotient[pidp_pkg::DIV_N_W-1:pidp_pkg::FRAC_W] != '0
	                   || quotient[pidp_pkg::FRAC_W-1:0] > dmax_eff)
	                ? dmax_eff : quotient[pidp_pkg::FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			phase_positive <= dir_q;
			quiet_active   <= quiet_q;
			duty_fraction  <= quiet_q ? '0 : duty_q17;
			effort         <= quiet_q ? '0
			                : usat_q[pidp_pkg::USAT_W-1] ? pidp_pkg::ERR_W'(-eff_mag) : eff_mag;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

>>> rtl/core/pidp_ctrl.sv
// ----------------------------------------------------------------------------
// pidp_ctrl
// sequencer: load, four multiplies, saturate, divide, hand over the result
// ----------------------------------------------------------------------------
module pidp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pidp_pkg::status_t  stat,
	output pidp_pkg::cmd_t     cmd
);

	pidp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pidp_pkg::ST_IDLE:   if (in_valid) state_d = pidp_pkg::ST_PREP;
			pidp_pkg::ST_PREP:   state_d = pidp_pkg::ST_MUL_F;
			pidp_pkg::ST_MUL_F:  if (stat.mul_done) state_d = pidp_pkg::ST_MUL_P;
			pidp_pkg::ST_MUL_P:  if (stat.mul_done) state_d = pidp_pkg::ST_MUL_D;
			pidp_pkg::ST_MUL_D:  if (stat.mul_done) state_d = pidp_pkg::ST_MUL_I;
			pidp_pkg::ST_MUL_I:  if (stat.mul_done) state_d = pidp_pkg::ST_SAT;
			pidp_pkg::ST_SAT:    state_d = pidp_pkg::ST_DIV;
			pidp_pkg::ST_DIV:    if (stat.div_done) state_d = pidp_pkg::ST_FINISH;
			pidp_pkg::ST_FINISH: if (stat.out_free) state_d = pidp_pkg::ST_IDLE;
			default:             state_d = pidp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.start_op = pidp_pkg::OP_FILT;
		cmd.cap_op   = pidp_pkg::OP_FILT;
		in_ready     = 1'b0;
		unique case (state_q)
			pidp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pidp_pkg::ST_PREP: begin
				cmd.mul_start = 1'b1;
			end
			pidp_pkg::ST_MUL_F: begin
				cmd.cap           = stat.mul_done;
				cmd.mul_start     = stat.mul_done;
				cmd.start_op      = pidp_pkg::OP_PROP;
			end
			pidp_pkg::ST_MUL_P: begin
				cmd.cap           = stat.mul_done;
				cmd.cap_op        = pidp_pkg::OP_PROP;
				cmd.mul_start     = stat.mul_done;
				cmd.start_op      = pidp_pkg::OP_DERIV;
			end
			pidp_pkg::ST_MUL_D: begin
				cmd.cap           = stat.mul_done;
				cmd.cap_op        = pidp_pkg::OP_DERIV;
				cmd.mul_start     = stat.mul_done;
				cmd.start_op      = pidp_pkg::OP_INTEG;
			end
			pidp_pkg::ST_MUL_I: begin
				cmd.cap           = stat.mul_done;
				cmd.cap_op        = pidp_pkg::OP_INTEG;
			end
			pidp_pkg::ST_SAT: begin
				cmd.sat       = 1'b1;
				cmd.div_start = 1'b1;
			end
			pidp_pkg::ST_DIV: ;
			pidp_pkg::ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/core/pid_position_controller_pwm.sv
// ----------------------------------------------------------------------------
// pid_position_controller_pwm
// position PID with filtered derivative on measurement, anti-windup,
// hysteretic deadband and sign/magnitude PWM duty output
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        contents
//  in_ch     in    valid/ready      reference_position, measured_position
//  out_ch    out   valid/ready      phase_positive, duty_fraction,
//                                   quiet_active, effort
//  cfg       in    cfg_we only      cfg_index, cfg_data (no read-back)
//
//  an item goes from transfer to result valid through the load, four
//  passes of the shared shift-add multiplier, the saturate state, the
//  divide and the output load; the sequencer takes items one at a time;
//  in_ch.ready is high only while the sequencer is idle
//  a result waits in the output register while the next item is taken; the
//  sequencer holds in its final state until that register is free
//  arst_n clears the loop state, the registers to their defaults, no output
//
module pid_position_controller_pwm (
	input  logic                              clk,
	input  logic                              arst_n,
	pidp_in_if.sink                           in_ch,
	pidp_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [pidp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pidp_pkg::CFG_DAT_W-1:0]    cfg_data
);

	pidp_pkg::cmd_t    cmd;     // sequencer commands to the datapath
	pidp_pkg::status_t stat;    // unit done flags and output register state

	// sequencer
	pidp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, loop state, configuration and output register
	pidp_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.reference_position (in_ch.reference_position),
		.measured_position  (in_ch.measured_position),
		.cmd                (cmd),
		.stat               (stat),
		.out_ready          (out_ch.ready),
		.out_valid          (out_ch.valid),
		.phase_positive     (out_ch.phase_positive),
		.duty_fraction      (out_ch.duty_fraction),
		.quiet_active       (out_ch.quiet_active),
		.effort             (out_ch.effort)
	);

endmodule
